>>> sv/fefr_pkg.sv
// ----------------------------------------------------------------------------
// fefr_pkg
// Shared constants, types and destuffed-byte helper for the flag/escape frame
// receiver.
// ----------------------------------------------------------------------------
package fefr_pkg;

    localparam logic [7:0]  FLAG_BYTE        = 8'h7e;
    localparam logic [7:0]  ESC_BYTE         = 8'h7d;
    localparam logic [7:0]  ESC_CODE_ESC     = 8'h01;
    localparam logic [7:0]  ESC_CODE_FLAG    = 8'h02;
    localparam logic [7:0]  CHECK_INVERT     = 8'hff;
    localparam logic [2:0]  HDR_BYTES        = 3'd4;
    localparam logic [9:0]  PAYLOAD_CAP      = 10'd1020;
    localparam logic [10:0] RAW_CAP          = 11'd2047;
    localparam int unsigned FER_MAX_FRAME_BYTES = 1024;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_BAD_CHECK = 2'd1,
        ST_SHORT     = 2'd2,
        ST_LONG      = 2'd3
    } t_frame_status;

    typedef struct packed {
        logic        escape_pending;
        logic [2:0]  header_index;
        logic [7:0]  received_check;
        logic [7:0]  running_sum;
        logic [10:0] raw_count;
        logic [9:0]  payload_count;
    } t_frame_st;

    typedef struct packed {
        t_frame_st st;
        logic      emit;
    } t_take;

    typedef struct packed {
        logic [7:0]    data_byte;
        logic          end_of_frame;
        t_frame_status frame_status;
        logic [9:0]    payload_length;
    } t_result;

    // one destuffed byte: checksum, header or payload
    function automatic t_take take_byte(t_frame_st s, logic [7:0] d);
        t_take t;
        t.st   = s;
        t.emit = 1'b0;
        if (s.header_index == 3'd0) begin
            t.st.received_check = d;
            t.st.header_index   = 3'd1;
        end else begin
            t.st.running_sum = s.running_sum + d;
            if (s.header_index < HDR_BYTES) begin
                t.st.header_index = s.header_index + 3'd1;
            end else begin
                if (s.payload_count < PAYLOAD_CAP) begin
                    t.st.payload_count = s.payload_count + 10'd1;
                end
                t.emit = 1'b1;
            end
        end
        return t;
    endfunction

endpackage

>>> sv/flag_escape_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// flag_escape_frame_receiver_unit
// Byte-stuffed frame receiver: destuffs the raw byte stream, checks the
// inverted additive checksum and streams payload bytes, closing each frame
// with a status item.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : i_valid / o_ready with i_rx_byte, one raw byte per item
//   output channel : o_valid / i_ready with o_data_byte, o_end_of_frame,
//                    o_frame_status, o_payload_length
//   A raw byte yields zero, one or two output items. Payload items carry the
//   destuffed byte; the item closing a frame has o_end_of_frame set and
//   carries status and payload length. Downstream drops frames whose status
//   is not good.
//   An item's results are registered and valid in the cycle after it is accepted.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and i_ready is high; a byte that gives two results holds o_ready low until
//   the single output port has drained one entry of the two-entry result buffer.
//   Reset clears the frame state and empties the result buffer.
//   When the receiver stalls, results wait in the buffer; o_ready is low
//   while two results are held, or while one is held and i_ready is low.
// ----------------------------------------------------------------------------
module flag_escape_frame_receiver_unit #(
    parameter int unsigned MAX_FRAME_BYTES = fefr_pkg::FER_MAX_FRAME_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic       o_end_of_frame,
    output logic [1:0] o_frame_status,
    output logic [9:0] o_payload_length
);
    import fefr_pkg::*;

    logic          r_flag_parity;
    logic          n_flag_parity;
    t_frame_st     r_st;
    t_frame_st     n_st;
    t_result       r_slot0;
    t_result       n_slot0;
    t_result       r_slot1;
    t_result       n_slot1;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    logic          in_acc;
    logic          out_acc;
    logic          is_flag;
    logic          closing;
    logic          do_a;
    logic          do_b;
    logic [7:0]    d_a;
    logic [7:0]    d_b;
    t_frame_st     st0;
    t_frame_st     st1;
    t_frame_st     st2;
    t_take         tk_a;
    t_take         tk_b;
    logic          e_a;
    logic          e_b;
    t_frame_status status;
    t_result       res0;
    t_result       res1;
    logic [1:0]    nres;

    assign o_valid = (r_count != 2'd0);
    assign o_ready = (r_count == 2'd0) || ((r_count == 2'd1) && i_ready);
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    assign o_data_byte      = r_slot0.data_byte;
    assign o_end_of_frame   = r_slot0.end_of_frame;
    assign o_frame_status   = r_slot0.frame_status;
    assign o_payload_length = r_slot0.payload_length;

    // destuff decode: which bytes go through the frame logic
    always_comb begin
        is_flag = (i_rx_byte == FLAG_BYTE);
        closing = is_flag && r_flag_parity;
        do_a    = 1'b0;
        do_b    = 1'b0;
        d_a     = i_rx_byte;
        d_b     = i_rx_byte;
        st0     = r_st;
        if (is_flag) begin
            // trailing escape is kept as a byte
            if (closing && r_st.escape_pending) begin
                do_a               = 1'b1;
                d_a                = ESC_BYTE;
                st0.escape_pending = 1'b0;
            end
        end else begin
            if (r_st.raw_count != RAW_CAP) begin
                st0.raw_count = r_st.raw_count + 11'd1;
            end
            if (r_st.escape_pending) begin
                st0.escape_pending = 1'b0;
                do_a               = 1'b1;
                priority if (i_rx_byte == ESC_CODE_ESC) begin
                    d_a = ESC_BYTE;
                end else if (i_rx_byte == ESC_CODE_FLAG) begin
                    d_a = FLAG_BYTE;
                end else begin
                    d_a  = ESC_BYTE;
                    do_b = 1'b1;
                end
            end else if (i_rx_byte == ESC_BYTE) begin
                st0.escape_pending = 1'b1;
            end else begin
                do_a = 1'b1;
            end
        end
    end

    always_comb begin
        tk_a = take_byte(st0, d_a);
        st1  = do_a ? tk_a.st : st0;
        e_a  = do_a && tk_a.emit;
        tk_b = take_byte(st1, d_b);
        st2  = do_b ? tk_b.st : st1;
        e_b  = do_b && tk_b.emit;

        if (32'(st1.raw_count) > MAX_FRAME_BYTES) begin
            status = ST_LONG;
        end else if (st1.header_index < HDR_BYTES) begin
            status = ST_SHORT;
        end else if ((st1.running_sum ^ CHECK_INVERT) != st1.received_check) begin
            status = ST_BAD_CHECK;
        end else begin
            status = ST_GOOD;
        end
    end

    // pack the results of this item into at most two entries
    always_comb begin
        res0 = '{data_byte: 8'd0, end_of_frame: 1'b0, frame_status: ST_GOOD,
                 payload_length: 10'd0};
        res1 = res0;
        if (e_a) begin
            res0.data_byte = d_a;
        end
        if (e_b) begin
            if (e_a) begin
                res1.data_byte = d_b;
            end else begin
                res0.data_byte = d_b;
            end
        end
        if (closing) begin
            if (e_a) begin
                res1.end_of_frame   = 1'b1;
                res1.frame_status   = status;
                res1.payload_length = st1.payload_count;
            end else begin
                res0.end_of_frame   = 1'b1;
                res0.frame_status   = status;
                res0.payload_length = st1.payload_count;
            end
        end
        nres = {1'b0, e_a} + {1'b0, e_b} + {1'b0, closing};
    end

    always_comb begin
        n_flag_parity = r_flag_parity;
        n_st          = r_st;
        n_slot0       = r_slot0;
        n_slot1       = r_slot1;
        n_count       = r_count;
        if (out_acc) begin
            n_slot0 = r_slot1;
            n_count = r_count - 2'd1;
        end
        if (in_acc) begin
            // buffer is empty after any pop when an item is taken
            n_slot0 = res0;
            n_slot1 = res1;
            n_count = nres;
            if (is_flag) begin
                n_flag_parity = ~r_flag_parity;
                n_st          = closing ? '0 : r_st;
            end else begin
                n_st = st2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_parity <= 1'b0;
            r_st          <= '0;
            r_count       <= 2'd0;
        end else begin
            r_flag_parity <= n_flag_parity;
            r_st          <= n_st;
            r_count       <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

>>> dv/flag_escape_frame_receiver_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flag_escape_frame_receiver_unit_test
// Self-checking bench for the byte-stuffed frame receiver. Raw bytes go in
// through a queue-fed driver; a bit-accurate deframer model predicts payload
// and end-of-frame items, which the monitor checks in order under random
// stalls on both sides.
// ----------------------------------------------------------------------------
module flag_escape_frame_receiver_unit_test;
    import fefr_pkg::*;

    localparam int unsigned MAX_FRAME   = FER_MAX_FRAME_BYTES;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          N_ITEMS     = 1200;

    typedef struct packed {
        logic       hold;
        logic [7:0] data;
    } raw_item_t;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'd0;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_data_byte;
    logic       o_end_of_frame;
    logic [1:0] o_frame_status;
    logic [9:0] o_payload_length;

    raw_item_t tx_items[$];
    t_result   awaited_results[$];
    logic      hold_next  = 1'b0;
    int        n_total    = 0;
    int        n_accepted = 0;
    int        n_errors   = 0;
    int        n_cycles   = 0;

    // deframer state, mirrors the block after reset
    logic        flag_open = 1'b0;
    logic        esc_wait  = 1'b0;
    logic [2:0]  hdr_idx   = 3'd0;
    logic [7:0]  rx_check  = 8'd0;
    logic [7:0]  byte_sum  = 8'd0;
    logic [10:0] raw_cnt   = 11'd0;
    logic [9:0]  pay_cnt   = 10'd0;

    wire [6:0] send_idle_pct = (n_accepted < n_total / 3)     ? 7'd38 :
                               (n_accepted < 2 * n_total / 3) ? 7'd58 : 7'd0;
    wire [6:0] recv_idle_pct = (n_accepted < n_total / 3)     ? 7'd58 :
                               (n_accepted < 2 * n_total / 3) ? 7'd38 : 7'd0;

    flag_escape_frame_receiver_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_data_byte      (o_data_byte),
        .o_end_of_frame   (o_end_of_frame),
        .o_frame_status   (o_frame_status),
        .o_payload_length (o_payload_length)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // deframer model
    // ------------------------------------------------------------------
    function automatic void queue_result(input logic [7:0] d, input logic eof,
                                         input t_frame_status st, input logic [9:0] len);
        t_result r;
        r.data_byte      = d;
        r.end_of_frame   = eof;
        r.frame_status   = st;
        r.payload_length = len;
        awaited_results.push_back(r);
    endfunction

    // checksum byte first, then three header bytes, then payload
    function automatic void absorb_byte(input logic [7:0] d);
        if (hdr_idx == 3'd0) begin
            rx_check = d;
            hdr_idx  = 3'd1;
        end else begin
            byte_sum = byte_sum + d;
            if (hdr_idx < HDR_BYTES) begin
                hdr_idx = hdr_idx + 3'd1;
            end else begin
                if (pay_cnt < PAYLOAD_CAP)
                    pay_cnt = pay_cnt + 10'd1;
                queue_result(d, 1'b0, ST_GOOD, 10'd0);
            end
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        t_frame_status st;
        if (b == FLAG_BYTE) begin
            if (!flag_open) begin
                flag_open = 1'b1;
            end else begin
                flag_open = 1'b0;
                // escape left hanging at the close is kept as a plain escape byte
                if (esc_wait) begin
                    esc_wait = 1'b0;
                    absorb_byte(ESC_BYTE);
                end
                if (int'(raw_cnt) > MAX_FRAME)
                    st = ST_LONG;
                else if (hdr_idx < HDR_BYTES)
                    st = ST_SHORT;
                else if ((byte_sum ^ CHECK_INVERT) != rx_check)
                    st = ST_BAD_CHECK;
                else
                    st = ST_GOOD;
                queue_result(8'd0, 1'b1, st, pay_cnt);
                esc_wait = 1'b0;
                hdr_idx  = 3'd0;
                rx_check = 8'd0;
                byte_sum = 8'd0;
                raw_cnt  = 11'd0;
                pay_cnt  = 10'd0;
            end
        end else begin
            if (raw_cnt < RAW_CAP)
                raw_cnt = raw_cnt + 11'd1;
            if (esc_wait) begin
                esc_wait = 1'b0;
                if (b == ESC_CODE_ESC) begin
                    absorb_byte(ESC_BYTE);
                end else if (b == ESC_CODE_FLAG) begin
                    absorb_byte(FLAG_BYTE);
                end else begin
                    absorb_byte(ESC_BYTE);
                    absorb_byte(b);
                end
            end else if (b == ESC_BYTE) begin
                esc_wait = 1'b1;
            end else begin
                absorb_byte(b);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    function automatic void push_raw(input logic [7:0] b);
        raw_item_t it;
        it.data   = b;
        it.hold   = hold_next || ($urandom_range(0, 149) == 0);
        hold_next = 1'b0;
        tx_items.push_back(it);
    endfunction

    function automatic void push_stuffed(input logic [7:0] d);
        if (d == FLAG_BYTE) begin
            push_raw(ESC_BYTE);
            push_raw(ESC_CODE_FLAG);
        end else if (d == ESC_BYTE) begin
            push_raw(ESC_BYTE);
            push_raw(ESC_CODE_ESC);
        end else begin
            push_raw(d);
        end
    endfunction

    // biased toward the framing codes
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0:       b = FLAG_BYTE;
            1:       b = ESC_BYTE;
            2:       b = ESC_CODE_ESC;
            3:       b = ESC_CODE_FLAG;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pick_noise();
        logic [7:0] b;
        b = pick_byte();
        if (b == FLAG_BYTE)
            b = ESC_BYTE;
        return b;
    endfunction

    // plain frames carry no framing codes, so raw length is exact
    function automatic void add_frame(input int n_body, input bit plain);
        logic [7:0] body[$];
        logic [7:0] csum;
        logic [7:0] chk;
        logic [7:0] b;
        csum = 8'd0;
        for (int i = 0; i < n_body; i++) begin
            b = plain ? 8'($urandom_range(0, 255)) : pick_byte();
            if (plain && (b == FLAG_BYTE || b == ESC_BYTE))
                b = b ^ 8'h10;
            body.push_back(b);
            csum = csum + b;
        end
        chk = ~csum;
        if ($urandom_range(0, 5) == 0)
            chk = chk ^ 8'($urandom_range(1, 255));
        if (plain && (chk == FLAG_BYTE || chk == ESC_BYTE))
            chk = 8'h00;
        push_raw(FLAG_BYTE);
        push_stuffed(chk);
        foreach (body[i]) begin
            // unstuffed escape pair, passes through as two bytes
            if (!plain && $urandom_range(0, 30) == 0) begin
                b = 8'($urandom_range(0, 255));
                if (b == ESC_CODE_ESC || b == ESC_CODE_FLAG || b == FLAG_BYTE)
                    b = ESC_BYTE;
                push_raw(ESC_BYTE);
                push_raw(b);
            end
            push_stuffed(body[i]);
        end
        if (!plain && $urandom_range(0, 15) == 0)
            push_raw(ESC_BYTE);
        push_raw(FLAG_BYTE);
    endfunction

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_side
        raw_item_t head;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                deframe_byte(i_rx_byte);
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                head = (tx_items.size() != 0) ? tx_items[0] : '0;
                if (tx_items.size() != 0 && !(head.hold && awaited_results.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_rx_byte <= head.data;
                    i_valid   <= 1'b1;
                    void'(tx_items.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_side
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (awaited_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected item: data %h eof %b status %0d len %0d",
                                 o_data_byte, o_end_of_frame, o_frame_status,
                                 o_payload_length);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_data_byte !== want.data_byte
                        || o_end_of_frame !== want.end_of_frame
                        || o_frame_status !== want.frame_status
                        || o_payload_length !== want.payload_length) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"mismatch: expected data %h eof %b status %0d len %0d,",
                                      " got data %h eof %b status %0d len %0d"},
                                     want.data_byte, want.end_of_frame, want.frame_status,
                                     want.payload_length, o_data_byte, o_end_of_frame,
                                     o_frame_status, o_payload_length);
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : main_seq
        logic [7:0] directed_seq [22] = '{
            // stray byte before the opening flag, escape held across it,
            // escape then escape, both stuffed codes, pass-through pair,
            // escape still pending at the closing flag
            8'h00, ESC_BYTE, FLAG_BYTE, ESC_BYTE, 8'hff, ESC_BYTE, ESC_CODE_ESC,
            ESC_BYTE, ESC_CODE_FLAG, ESC_BYTE, 8'h33, 8'hff, ESC_BYTE, FLAG_BYTE,
            // empty frame
            FLAG_BYTE, FLAG_BYTE,
            // header only, good checksum, no payload
            FLAG_BYTE, 8'hff, 8'h00, 8'h00, 8'h00, FLAG_BYTE
        };
        int n_frames;
        int pick;
        int n;

        foreach (directed_seq[i])
            push_raw(directed_seq[i]);

        n_frames  = 0;
        hold_next = 1'b1;
        while (tx_items.size() < N_ITEMS) begin
            n_frames++;
            pick = $urandom_range(0, 19);
            if (n_frames == 8) begin
                // raw length one past the limit, payload past its cap
                add_frame(1024, 1'b1);
            end else if (pick < 14) begin
                add_frame($urandom_range(0, 20), $urandom_range(0, 3) == 0);
            end else if (pick < 16) begin
                n = $urandom_range(1, 4);
                repeat (n) push_raw(pick_noise());
            end else if (pick < 19) begin
                n = $urandom_range(0, 6);
                push_raw(FLAG_BYTE);
                repeat (n) push_raw(pick_noise());
                push_raw(FLAG_BYTE);
            end else begin
                // extra flag on each side shifts the parity and then restores it
                push_raw(FLAG_BYTE);
                add_frame($urandom_range(0, 10), 1'b0);
                push_raw(FLAG_BYTE);
            end
        end
        n_total = tx_items.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < n_total)
            @(posedge i_clk);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("timeout after %0d cycles", n_cycles);
        $display("TEST FAILED");
        $finish;
    end

endmodule
